FILE: sv/h2r_pkg.sv
// Shared types, constants and scaling helpers for the rainbow HSV to RGB converter.
// Depends on nothing; every other file of the block but h2r_if imports it.
package h2r_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   // Ramp scale factors, given as k where the plain scale multiplies by k + 1.
   localparam logic [7:0] ONE_THIRD = 8'd85;
   localparam logic [7:0] TWO_THIRD = 8'd170;
   localparam logic [7:0] FULL_LVL  = 8'd255;

   // Work handed from the front to the back: the sector color and the
   // scale factors that the back still has to apply.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       sat_full;
      logic [7:0] keep;
      logic [7:0] floor_lvl;
      logic       val_full;
      logic [7:0] lvl;
   } work_type;

   // Plain scale: (x * (k + 1)) >> 8.
   function automatic logic [7:0] scale_plain(input logic [7:0] x, input logic [7:0] k);
      logic [15:0] prod;
      prod = {8'd0, x} * ({8'd0, k} + 16'd1);
      return prod[15:8];
   endfunction

   // Video scale of a value by itself: ((x * x) >> 8) + 1 when x is nonzero.
   function automatic logic [7:0] square_video(input logic [7:0] x);
      logic [15:0] prod;
      prod = x * x;
      return prod[15:8] + {7'd0, (x != 8'd0)};
   endfunction

endpackage

FILE: sv/h2r_if.sv
// Valid/ready channel interfaces for the pixel request and response streams.
// Depends on nothing.
interface h2r_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface h2r_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: sv/h2r_front.sv
// Front end: accepts pixels, picks the rainbow sector and precomputes the scale factors.
// Depends on h2r_pkg and h2r_if.
module h2r_front (
   input  logic              clock,
   input  logic              reset,
   h2r_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output h2r_pkg::work_type push_work
);
   import h2r_pkg::*;

   localparam logic [2:0] SEC_RED    = 3'd0;
   localparam logic [2:0] SEC_ORANGE = 3'd1;
   localparam logic [2:0] SEC_YELLOW = 3'd2;
   localparam logic [2:0] SEC_GREEN  = 3'd3;
   localparam logic [2:0] SEC_AQUA   = 3'd4;
   localparam logic [2:0] SEC_BLUE   = 3'd5;
   localparam logic [2:0] SEC_PURPLE = 3'd6;
   localparam logic [2:0] SEC_PINK   = 3'd7;

   logic       valid_ff, valid_in;
   work_type   work_ff, work_in;
   logic [7:0] ramp, one3, two3, desat;

   assign ramp  = {req.hue[4:0], 3'b000};
   assign one3  = scale_plain(ramp, ONE_THIRD);
   assign two3  = scale_plain(ramp, TWO_THIRD);
   assign desat = FULL_LVL - req.saturation;

   always_comb begin
      work_in = '0;
      unique case (req.hue[7:5])
         SEC_RED: begin
            work_in.red = 8'd255 - one3; work_in.green = one3; work_in.blue = 8'd0;
         end
         SEC_ORANGE: begin
            work_in.red = 8'd171; work_in.green = 8'd85 + one3; work_in.blue = 8'd0;
         end
         SEC_YELLOW: begin
            work_in.red = 8'd171 - two3; work_in.green = 8'd170 + one3;
            work_in.blue = 8'd0;
         end
         SEC_GREEN: begin
            work_in.red = 8'd0; work_in.green = 8'd255 - one3; work_in.blue = one3;
         end
         SEC_AQUA: begin
            work_in.red = 8'd0; work_in.green = 8'd171 - two3;
            work_in.blue = 8'd85 + two3;
         end
         SEC_BLUE: begin
            work_in.red = one3; work_in.green = 8'd0; work_in.blue = 8'd255 - one3;
         end
         SEC_PURPLE: begin
            work_in.red = 8'd85 + one3; work_in.green = 8'd0;
            work_in.blue = 8'd171 - one3;
         end
         SEC_PINK: begin
            work_in.red = 8'd170 + one3; work_in.green = 8'd0;
            work_in.blue = 8'd85 - one3;
         end
         default: begin
            work_in.red = 8'd0; work_in.green = 8'd0; work_in.blue = 8'd0;
         end
      endcase
      work_in.sat_full  = (req.saturation == FULL_LVL);
      work_in.floor_lvl = square_video(desat);
      work_in.keep      = FULL_LVL - square_video(desat);
      work_in.val_full  = (req.brightness == FULL_LVL);
      work_in.lvl       = square_video(req.brightness);
   end

   assign req.ready  = !valid_ff || push_ready;
   assign valid_in   = req.valid || (valid_ff && !push_ready);
   assign push_valid = valid_ff;
   assign push_work  = work_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         work_ff <= work_in;
      end
   end

endmodule

FILE: sv/h2r_queue.sv
// Short FIFO of pending work between the front and the back of the converter.
// Depends on h2r_pkg.
module h2r_queue #(
   parameter int unsigned Depth = h2r_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  h2r_pkg::work_type push_work,
   output logic              pop_valid,
   input  logic              pop_ready,
   output h2r_pkg::work_type pop_work
);
   import h2r_pkg::*;

   localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountW = $clog2(Depth + 1);
   localparam logic [AddrW-1:0]  LastAddr  = AddrW'(Depth - 1);
   localparam logic [CountW-1:0] FullCount = CountW'(Depth);

   work_type          mem [Depth];
   logic [AddrW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign pop_valid  = (count_ff != '0);
   assign push_ready = (count_ff != FullCount) || pop_ready;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_work   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastAddr) ? '0 : wr_ptr_ff + AddrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastAddr) ? '0 : rd_ptr_ff + AddrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_work;
      end
   end

endmodule

FILE: sv/h2r_back.sv
// Back end: applies desaturation, then brightness, and holds the result for the receiver.
// Depends on h2r_pkg and h2r_if.
module h2r_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  h2r_pkg::work_type pop_work,
   h2r_rsp_if.source         rsp
);
   import h2r_pkg::*;

   logic       advance;
   logic       s1_valid_ff, out_valid_ff;
   logic [7:0] s1_red_ff, s1_green_ff, s1_blue_ff, s1_lvl_ff;
   logic [7:0] s1_red_in, s1_green_in, s1_blue_in;
   logic       s1_val_full_ff;
   logic [7:0] out_red_ff, out_green_ff, out_blue_ff;
   logic [7:0] out_red_in, out_green_in, out_blue_in;

   assign advance   = !out_valid_ff || rsp.ready;
   assign pop_ready = advance;

   // Desaturation: scale the color down and lift it by the floor; the sum stays in 8 bits.
   always_comb begin
      if (pop_work.sat_full) begin
         s1_red_in   = pop_work.red;
         s1_green_in = pop_work.green;
         s1_blue_in  = pop_work.blue;
      end else begin
         s1_red_in   = scale_plain(pop_work.red, pop_work.keep) + pop_work.floor_lvl;
         s1_green_in = scale_plain(pop_work.green, pop_work.keep) + pop_work.floor_lvl;
         s1_blue_in  = scale_plain(pop_work.blue, pop_work.keep) + pop_work.floor_lvl;
      end
   end

   always_comb begin
      if (s1_val_full_ff) begin
         out_red_in   = s1_red_ff;
         out_green_in = s1_green_ff;
         out_blue_in  = s1_blue_ff;
      end else begin
         out_red_in   = scale_plain(s1_red_ff, s1_lvl_ff);
         out_green_in = scale_plain(s1_green_ff, s1_lvl_ff);
         out_blue_in  = scale_plain(s1_blue_ff, s1_lvl_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= pop_valid;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_red_ff      <= s1_red_in;
         s1_green_ff    <= s1_green_in;
         s1_blue_ff     <= s1_blue_in;
         s1_val_full_ff <= pop_work.val_full;
         s1_lvl_ff      <= pop_work.lvl;
         out_red_ff     <= out_red_in;
         out_green_ff   <= out_green_in;
         out_blue_ff    <= out_blue_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.red   = out_red_ff;
   assign rsp.green = out_green_ff;
   assign rsp.blue  = out_blue_ff;

endmodule

FILE: sv/hsv_to_rgb_rainbow.sv
// Top level of the 8-bit rainbow HSV to RGB pixel converter.
// Depends on h2r_pkg, h2r_if, h2r_front, h2r_queue and h2r_back.
//
// Usage:
//   Pixels arrive on the req channel (hue, saturation, brightness) and leave on
//   the rsp channel (red, green, blue), one response transaction per request
//   transaction, in order. There are no configuration registers.
// Throughput: one pixel per clock cycle as long as the receiver keeps ready high.
// Path: a pixel accepted on req is loaded into the front register, then written
//   into the queue, then passes the back pipeline (desaturation multiply, then
//   brightness multiply) before it appears on rsp. The multipliers, one per
//   register stage, set the depth of the back pipeline.
// Stalls: when the receiver holds ready low, the back pipeline freezes with its
//   result held on rsp; the queue between front and back keeps absorbing pixels
//   until it fills, and only then does req.ready fall.
// Reset: synchronous and active high; it empties the front register, the queue
//   and the back pipeline. No pixel is left pending, but the data registers are not reset.
module hsv_to_rgb_rainbow #(
   parameter int unsigned QueueDepth = h2r_pkg::QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   h2r_req_if.sink   req,
   h2r_rsp_if.source rsp
);
   import h2r_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   work_type push_work, pop_work;

   // Front: sector selection and scale factors.
   h2r_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work)
   );

   // Queue decoupling front stalls from back stalls.
   h2r_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_work   (pop_work)
   );

   // Back: desaturation and brightness scaling, output register.
   h2r_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_work  (pop_work),
      .rsp       (rsp)
   );

endmodule

FILE: verif/h2r_checker.sv
`timescale 1ns / 100ps
// Pixel checker for the rainbow HSV to RGB converter: predicts and compares responses.
// Depends on h2r_pkg for the ramp constants; it watches the channels through plain ports.
module h2r_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_brightness,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   output int         fail_count,
   output int         outstanding
);
   import h2r_pkg::*;

   localparam logic [7:0] ONE_THIRD_UP = 8'd171;

   typedef enum logic [2:0] {
      SECT_RED, SECT_ORANGE, SECT_YELLOW, SECT_GREEN,
      SECT_AQUA, SECT_BLUE, SECT_PURPLE, SECT_PINK
   } sector_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_expect_type;

   pixel_expect_type expected_px[$];

   // x * (k + 1) / 256, which never leaves 16 bits for 8-bit operands.
   function automatic logic [7:0] plain_scale(input logic [7:0] x, input logic [7:0] k);
      logic [15:0] p;
      p = 16'(x) * 16'(k) + 16'(x);
      return p[15:8];
   endfunction

   // x * k / 256, bumped by one so that nonzero inputs never vanish.
   function automatic logic [7:0] video_scale(input logic [7:0] x, input logic [7:0] k);
      logic [15:0] p;
      p = 16'(x) * 16'(k);
      return p[15:8] + ((x != 8'd0 && k != 8'd0) ? 8'd1 : 8'd0);
   endfunction

   function automatic pixel_expect_type rainbow_pixel(input logic [7:0] hue,
                                                      input logic [7:0] sat,
                                                      input logic [7:0] bri);
      pixel_expect_type px;
      logic [7:0] ramp, one3, two3, r, g, b, floor_lvl, keep, lvl;
      ramp = {hue[4:0], 3'b000};
      one3 = plain_scale(ramp, ONE_THIRD);
      two3 = plain_scale(ramp, TWO_THIRD);
      case (sector_type'(hue[7:5]))
         SECT_RED: begin
            r = FULL_LVL - one3;     g = one3;                 b = 8'd0;
         end
         SECT_ORANGE: begin
            r = ONE_THIRD_UP;        g = ONE_THIRD + one3;     b = 8'd0;
         end
         SECT_YELLOW: begin
            r = ONE_THIRD_UP - two3; g = TWO_THIRD + one3;     b = 8'd0;
         end
         SECT_GREEN: begin
            r = 8'd0;                g = FULL_LVL - one3;      b = one3;
         end
         SECT_AQUA: begin
            r = 8'd0;                g = ONE_THIRD_UP - two3;  b = ONE_THIRD + two3;
         end
         SECT_BLUE: begin
            r = one3;                g = 8'd0;                 b = FULL_LVL - one3;
         end
         SECT_PURPLE: begin
            r = ONE_THIRD + one3;    g = 8'd0;                 b = ONE_THIRD_UP - one3;
         end
         default: begin
            r = TWO_THIRD + one3;    g = 8'd0;                 b = ONE_THIRD - one3;
         end
      endcase
      if (sat != FULL_LVL) begin
         floor_lvl = video_scale(~sat, ~sat);
         keep      = ~floor_lvl;
         r = plain_scale(r, keep) + floor_lvl;
         g = plain_scale(g, keep) + floor_lvl;
         b = plain_scale(b, keep) + floor_lvl;
      end
      if (bri != FULL_LVL) begin
         lvl = video_scale(bri, bri);
         r = plain_scale(r, lvl);
         g = plain_scale(g, lvl);
         b = plain_scale(b, lvl);
      end
      px = '{hue: hue, saturation: sat, brightness: bri, red: r, green: g, blue: b};
      return px;
   endfunction

   task automatic note_mismatch(input string what);
      fail_count++;
      $display("%0t ns checker: %s", $time, what);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want, input pixel_expect_type px);
      if (got !== want)
         note_mismatch($sformatf("%s got %0d expected %0d for hsv %02h %02h %02h",
                                 name, got, want, px.hue, px.saturation, px.brightness));
   endtask

   always @(posedge clock) begin
      pixel_expect_type want;
      if (!reset && req_valid && req_ready)
         expected_px.push_back(rainbow_pixel(req_hue, req_saturation, req_brightness));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_px.size() == 0) begin
            note_mismatch($sformatf("response %02h %02h %02h with no pixel outstanding",
                                    rsp_red, rsp_green, rsp_blue));
         end else begin
            want = expected_px.pop_front();
            check_field("red",   rsp_red,   want.red,   want);
            check_field("green", rsp_green, want.green, want);
            check_field("blue",  rsp_blue,  want.blue,  want);
         end
      end
      outstanding <= expected_px.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the rainbow HSV to RGB testbench: clock, reset, pixel stimulus, response stalls.
// Depends on h2r_pkg, h2r_if, hsv_to_rgb_rainbow and h2r_checker.
module tb_top;
   import h2r_pkg::*;

   // Slowest legal run is roughly 475 pixels, each with the longest idle gap, the longest
   // stall and the latency; the limit leaves a wide margin on top of that.
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PIXELS = 450;
   localparam int MAX_WAIT = 12;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   cycle_count;
   int   rsp_wait;
   int   rsp_seen;

   h2r_req_if req_ch ();
   h2r_rsp_if rsp_ch ();

   hsv_to_rgb_rainbow dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // The checker sees every transaction on both channels, predicts each pixel
   // and reports any mismatch; the top only drives and judges.
   h2r_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_hue        (req_ch.hue),
      .req_saturation (req_ch.saturation),
      .req_brightness (req_ch.brightness),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_red        (rsp_ch.red),
      .rsp_green      (rsp_ch.green),
      .rsp_blue       (rsp_ch.blue),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver side. After every accepted response transaction a fresh stall is
   // drawn; ready stays low while that stall counts down. Every fourth window of 16
   // responses the receiver runs without stalls, so back-to-back output and
   // long stalls both hit every pipeline stage. Ready is assigned exactly once
   // per edge, so a zero stall keeps it high without a glitch.
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait     <= 0;
         rsp_seen     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         stall = ((rsp_seen % 64) < 16) ? 0 : $urandom_range(0, MAX_WAIT);
         rsp_seen     <= rsp_seen + 1;
         rsp_wait     <= stall;
         rsp_ch.ready <= (stall == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_ch.ready <= (rsp_wait == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Presents one pixel after an idle gap and holds it until the block takes it.
   // With a zero gap, valid stays high from the previous transaction.
   task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                             input logic [7:0] bri, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.hue        <= hue;
      req_ch.saturation <= sat;
      req_ch.brightness <= bri;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Stops sending and waits until every predicted pixel has come back.
   task automatic drain;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Saturation and brightness lean toward the levels that skip or saturate a
   // stage, since those take different paths through the block.
   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0, 1:    return FULL_LVL;
         2:       return 8'd0;
         3:       return 8'(FULL_LVL - 1);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      bit calm;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.hue        <= 8'd0;
      req_ch.saturation <= 8'd0;
      req_ch.brightness <= 8'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Each sector at the top of its ramp with the scaling
      // stages bypassed, then each sector at its start with mixed levels.
      for (int sec = 0; sec < 8; sec++)
         send_pixel({sec[2:0], 5'h1f}, FULL_LVL, FULL_LVL, 0);
      for (int sec = 0; sec < 8; sec++)
         send_pixel({sec[2:0], 5'h00}, 8'(sec * 37), 8'(255 - sec * 29), sec % 3);
      // Zero saturation turns every channel white; zero brightness makes black.
      send_pixel(8'h00, 8'd0,   FULL_LVL, 0);
      send_pixel(8'h00, FULL_LVL, 8'd0,   0);
      send_pixel(8'h00, 8'd0,   8'd0,     0);
      send_pixel(8'hff, FULL_LVL, FULL_LVL, 0);
      send_pixel(8'h55, 8'd1,   8'd1,     1);
      send_pixel(8'haa, 8'd254, 8'd254,   0);
      send_pixel(8'h37, 8'd128, 8'd128,   0);

      // The sender holds off here until the block has emptied completely.
      drain;

      // Random part. Each run of 40 pixels is drawn either with no gaps or with
      // random gaps, and the sender holds off once more midway.
      calm = 1'b0;
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 2) == 0);
         if (i == RANDOM_PIXELS / 2) drain;
         send_pixel(8'($urandom_range(0, 255)), pick_level(), pick_level(),
                    calm ? 0 : $urandom_range(0, MAX_WAIT));
      end

      drain;
      // Let the pipeline settle so that a stray extra response would show up.
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
sv/h2r_pkg.sv
sv/h2r_if.sv
sv/h2r_front.sv
sv/h2r_queue.sv
sv/h2r_back.sv
sv/hsv_to_rgb_rainbow.sv
verif/h2r_checker.sv
verif/tb_top.sv
